// ----- rtl/blmt_pkg.sv -----
// Shared types, constants and register codes for the binned lookup mean table.
package blmt_pkg;

    localparam int DEPTH = 4096;
    localparam int IDX_W = 12;
    localparam int CNT_W = 16;
    localparam int ESUM_W = 32;
    localparam int PSUM_W = 38;
    localparam int ASUM_W = 40;
    localparam int EN_W = 16;
    localparam int POL_W = 22;
    localparam int AZ_W = 23;
    localparam int DIV_W = 40;
    localparam int CLR_W = 13;

    localparam int BINS_X_DEF = 8;
    localparam int BINS_Y_DEF = 8;
    localparam int BINS_SX_DEF = 8;
    localparam int BINS_SY_DEF = 8;

    localparam logic [1:0] ACT_TRAIN = 2'd0;
    localparam logic [1:0] ACT_RECO = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] DIV_ENERGY = 2'd0;
    localparam logic [1:0] DIV_POLAR = 2'd1;
    localparam logic [1:0] DIV_AZIMUTH = 2'd2;

    localparam logic [2:0] REG_X_ORG = 3'd0;
    localparam logic [2:0] REG_X_SCL = 3'd1;
    localparam logic [2:0] REG_Y_ORG = 3'd2;
    localparam logic [2:0] REG_Y_SCL = 3'd3;
    localparam logic [2:0] REG_SX_ORG = 3'd4;
    localparam logic [2:0] REG_SX_SCL = 3'd5;
    localparam logic [2:0] REG_SY_ORG = 3'd6;
    localparam logic [2:0] REG_SY_SCL = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_we;
        logic rd_issue;
        logic wr_back;
        logic div_start;
        logic [1:0] div_sel;
        logic out_load;
    } blmt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic addr_ok;
        logic cnt_zero;
        logic cnt_full;
        logic div_done;
    } blmt_sts_t;

endpackage

// ----- rtl/binned_lookup_mean_table_core.sv -----
// Top level of the binned lookup mean table.
// Each accepted word yields exactly one result word. A reconstruct or read of a filled cell
// runs three 40-bit divisions in turn in one shared radix-2 divider; a train, a miss, an empty
// cell or the unused action code skips them. A finished result that finds the previous one
// still waiting on m_tready holds the block until that one is taken. After reset a clearing
// pass zeroes all 4096 cells of the cell memories before the first word is accepted.
// Configuration is to be written only while no word is in flight; the block itself does not
// enforce this.
module binned_lookup_mean_table_core #(
    parameter int BINS_X = blmt_pkg::BINS_X_DEF,
    parameter int BINS_Y = blmt_pkg::BINS_Y_DEF,
    parameter int BINS_SLOPE_X = blmt_pkg::BINS_SX_DEF,
    parameter int BINS_SLOPE_Y = blmt_pkg::BINS_SY_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, pos_x, pos_y, slope_x, slope_y, true_energy, true_polar,
    // true_azimuth, read_index from bit 0 up.
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_hit, cell_index, sample_count, mean_energy, mean_polar,
    // mean_azimuth from bit 0 up.
    output logic [95:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    blmt_pkg::blmt_cmd_t cmd;
    blmt_pkg::blmt_sts_t sts;
    logic [15:0] rd16;
    logic [89:0] ow;
    logic unused;

    assign pready = 1'b1;
    assign prdata = {16'd0, rd16};
    assign m_tdata = {6'd0, ow};
    assign unused = ^{s_tdata[143:139], paddr[1:0], pwdata[31:16]};

    blmt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .sts(sts)
    );

    blmt_datapath #(
        .BINS_X(BINS_X), .BINS_Y(BINS_Y),
        .BINS_SLOPE_X(BINS_SLOPE_X), .BINS_SLOPE_Y(BINS_SLOPE_Y)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(psel && penable && pwrite),
        .cfg_addr(paddr[4:2]), .cfg_data(pwdata[15:0]), .cfg_rdata(rd16),
        .in_word({1'b0, s_tdata[126:0]}), .in_read_index(s_tdata[138:127]),
        .out_word(ow)
    );
endmodule

// ----- rtl/blmt_div.sv -----
// Iterative restoring divider, one quotient bit a cycle, rounding to nearest.
module blmt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [blmt_pkg::DIV_W-1:0]    dividend,
    input  logic [blmt_pkg::CNT_W-1:0]    divisor,
    output logic [blmt_pkg::DIV_W-1:0]    quotient,
    output logic                          done
);
    localparam int CW = $clog2(blmt_pkg::DIV_W + 1);
    localparam int RW = blmt_pkg::CNT_W + 1;

    logic [blmt_pkg::DIV_W-1:0] q_reg, q_next;
    logic [RW-1:0] r_reg, r_next;
    logic [blmt_pkg::CNT_W-1:0] d_reg;
    logic [CW-1:0] n_reg;
    logic busy_reg, done_reg;
    logic [RW-1:0] trial;

    always_comb begin
        trial = {r_reg[RW-2:0], q_reg[blmt_pkg::DIV_W-1]};
        q_next = {q_reg[blmt_pkg::DIV_W-2:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, d_reg}) begin
            r_next = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // Adding half the divisor gives round to nearest, ties up.
                q_reg <= dividend + blmt_pkg::DIV_W'(divisor >> 1);
                r_reg <= '0;
                d_reg <= divisor;
                n_reg <= CW'(blmt_pkg::DIV_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                q_reg <= q_next;
                r_reg <= r_next;
                n_reg <= n_reg - 1'b1;
                if (n_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done = done_reg;
endmodule

// ----- rtl/blmt_datapath.sv -----
// Datapath: registers, binning, cell memories, divider and result register.
module blmt_datapath #(
    parameter int BINS_X = blmt_pkg::BINS_X_DEF,
    parameter int BINS_Y = blmt_pkg::BINS_Y_DEF,
    parameter int BINS_SLOPE_X = blmt_pkg::BINS_SX_DEF,
    parameter int BINS_SLOPE_Y = blmt_pkg::BINS_SY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  blmt_pkg::blmt_cmd_t  cmd,
    output blmt_pkg::blmt_sts_t  sts,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_addr,
    input  logic [15:0]          cfg_data,
    output logic [15:0]          cfg_rdata,
    input  logic [127:0]         in_word,
    input  logic [11:0]          in_read_index,
    output logic [89:0]          out_word
);
    localparam int TOTAL = BINS_X * BINS_Y * BINS_SLOPE_X * BINS_SLOPE_Y;

    logic [15:0] cfg_reg [8];
    logic [1:0] act_reg;
    logic [blmt_pkg::IDX_W-1:0] idx_reg;
    logic ok_reg;
    logic [15:0] en_reg;
    logic [21:0] pol_reg;
    logic [22:0] az_reg;

    logic [blmt_pkg::CNT_W-1:0] cnt_mem [blmt_pkg::DEPTH];
    logic [blmt_pkg::ESUM_W-1:0] e_mem [blmt_pkg::DEPTH];
    logic [blmt_pkg::PSUM_W-1:0] p_mem [blmt_pkg::DEPTH];
    logic [blmt_pkg::ASUM_W-1:0] a_mem [blmt_pkg::DEPTH];
    logic [blmt_pkg::CNT_W-1:0] cnt_rd;
    logic [blmt_pkg::ESUM_W-1:0] e_rd;
    logic [blmt_pkg::PSUM_W-1:0] p_rd;
    logic [blmt_pkg::ASUM_W-1:0] a_rd;
    logic [blmt_pkg::CLR_W-1:0] clr_reg;

    logic [15:0] me_reg;
    logic [21:0] mp_reg;
    logic [22:0] ma_reg;
    logic [blmt_pkg::CNT_W-1:0] cnt_out;
    logic hit_out;
    logic [89:0] out_reg, out_next;

    logic [blmt_pkg::DIV_W-1:0] div_in, div_q;
    logic div_done;
    logic a_neg;
    logic [blmt_pkg::ASUM_W-1:0] a_mag;

    logic [3:0] bin_ok;
    logic [6:0] bin_v [4];
    logic [31:0] lin;
    logic [15:0] px, py, psx, psy;

    assign px = in_word[17:2];
    assign py = in_word[33:18];
    assign psx = in_word[49:34];
    assign psy = in_word[65:50];

    function automatic logic [7:0] bin_of(input logic [15:0] v, input logic [15:0] org,
                                          input logic [15:0] scl, input int nb);
        logic signed [16:0] d;
        logic [32:0] p;
        logic [16:0] b;
        d = $signed({v[15], v}) - $signed({org[15], org});
        p = 33'(d[15:0]) * 33'(scl);
        b = p[32:16];
        if (d[16] || b >= 17'(nb)) return 8'h80;
        return {1'b0, b[6:0]};
    endfunction

    always_comb begin
        logic [7:0] r0, r1, r2, r3;
        r0 = bin_of(px, cfg_reg[0], cfg_reg[1], BINS_X);
        r1 = bin_of(py, cfg_reg[2], cfg_reg[3], BINS_Y);
        r2 = bin_of(psx, cfg_reg[4], cfg_reg[5], BINS_SLOPE_X);
        r3 = bin_of(psy, cfg_reg[6], cfg_reg[7], BINS_SLOPE_Y);
        bin_ok = {~r3[7], ~r2[7], ~r1[7], ~r0[7]};
        bin_v[0] = r0[6:0];
        bin_v[1] = r1[6:0];
        bin_v[2] = r2[6:0];
        bin_v[3] = r3[6:0];
        lin = ((32'(bin_v[0]) * 32'(BINS_Y) + 32'(bin_v[1])) * 32'(BINS_SLOPE_X)
               + 32'(bin_v[2])) * 32'(BINS_SLOPE_Y) + 32'(bin_v[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) cfg_reg[i] <= '0;
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end
    assign cfg_rdata = cfg_reg[cfg_addr];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= in_word[1:0];
            en_reg <= in_word[81:66];
            pol_reg <= in_word[103:82];
            az_reg <= in_word[126:104];
            if (in_word[1:0] == blmt_pkg::ACT_READ) begin
                idx_reg <= in_read_index;
                ok_reg <= 32'(in_read_index) < 32'(TOTAL);
            end else begin
                idx_reg <= lin[blmt_pkg::IDX_W-1:0];
                ok_reg <= (&bin_ok) && lin < 32'(blmt_pkg::DEPTH);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (cmd.clr_we) clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_we) begin
            cnt_mem[clr_reg[blmt_pkg::IDX_W-1:0]] <= '0;
            e_mem[clr_reg[blmt_pkg::IDX_W-1:0]] <= '0;
            p_mem[clr_reg[blmt_pkg::IDX_W-1:0]] <= '0;
            a_mem[clr_reg[blmt_pkg::IDX_W-1:0]] <= '0;
        end else if (cmd.wr_back) begin
            cnt_mem[idx_reg] <= cnt_rd + 1'b1;
            e_mem[idx_reg] <= e_rd + 32'(en_reg);
            p_mem[idx_reg] <= p_rd + 38'(pol_reg);
            a_mem[idx_reg] <= a_rd + {{17{az_reg[22]}}, az_reg};
        end
        if (cmd.rd_issue) begin
            cnt_rd <= cnt_mem[idx_reg];
            e_rd <= e_mem[idx_reg];
            p_rd <= p_mem[idx_reg];
            a_rd <= a_mem[idx_reg];
        end
    end

    assign a_neg = a_rd[blmt_pkg::ASUM_W-1];
    assign a_mag = a_neg ? (~a_rd + 1'b1) : a_rd;

    always_comb begin
        case (cmd.div_sel)
            blmt_pkg::DIV_ENERGY: div_in = 40'(e_rd);
            blmt_pkg::DIV_POLAR: div_in = 40'(p_rd);
            default: div_in = a_mag;
        endcase
    end

    blmt_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .dividend(div_in),
        .divisor(cnt_rd), .quotient(div_q), .done(div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            me_reg <= '0;
            mp_reg <= '0;
            ma_reg <= '0;
        end else if (div_done) begin
            case (cmd.div_sel)
                blmt_pkg::DIV_ENERGY: me_reg <= div_q[15:0];
                blmt_pkg::DIV_POLAR: mp_reg <= div_q[21:0];
                default: ma_reg <= a_neg ? (~div_q[22:0] + 1'b1) : div_q[22:0];
            endcase
        end
    end

    always_comb begin
        cnt_out = '0;
        hit_out = 1'b0;
        if (ok_reg && act_reg != blmt_pkg::ACT_UNUSED) begin
            if (act_reg == blmt_pkg::ACT_TRAIN) begin
                hit_out = 1'b1;
                cnt_out = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 1'b1;
            end else begin
                hit_out = cnt_rd != '0;
                cnt_out = cnt_rd;
            end
        end
    end

    always_comb begin
        out_next = '0;
        out_next[0] = hit_out;
        if (act_reg != blmt_pkg::ACT_UNUSED && (ok_reg || act_reg == blmt_pkg::ACT_READ))
            out_next[12:1] = idx_reg;
        out_next[28:13] = cnt_out;
        if (hit_out && act_reg != blmt_pkg::ACT_TRAIN) begin
            out_next[44:29] = me_reg;
            out_next[66:45] = mp_reg;
            out_next[89:67] = ma_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_reg <= out_next;
    end
    assign out_word = out_reg;

    assign sts.action = act_reg;
    assign sts.addr_ok = ok_reg;
    assign sts.cnt_zero = cnt_rd == '0;
    assign sts.cnt_full = cnt_rd == '1;
    assign sts.div_done = div_done;
endmodule

// ----- rtl/blmt_ctrl.sv -----
// Controller state machine sequencing clear, lookup, update and division.
module blmt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output blmt_pkg::blmt_cmd_t  cmd,
    input  blmt_pkg::blmt_sts_t  sts
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_DECIDE, ST_DIV, ST_DIVW, ST_LOAD
    } state_t;

    state_t state_reg;
    logic [12:0] clr_cnt_reg;
    logic [1:0] sel_reg;
    logic ovalid_reg;
    logic out_free;
    logic load_fire;

    assign out_free = !ovalid_reg || m_tready;
    assign load_fire = state_reg == ST_LOAD && out_free;

    always_comb begin
        cmd = '0;
        cmd.div_sel = sel_reg;
        cmd.capture = state_reg == ST_IDLE && s_tvalid;
        cmd.clr_we = state_reg == ST_CLEAR;
        cmd.rd_issue = state_reg == ST_READ;
        cmd.wr_back = state_reg == ST_DECIDE && sts.action == blmt_pkg::ACT_TRAIN
                      && sts.addr_ok && !sts.cnt_full;
        cmd.div_start = state_reg == ST_DIV;
        cmd.out_load = load_fire;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = ovalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            sel_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= load_fire || (ovalid_reg && !m_tready);
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == 13'(blmt_pkg::DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (s_tvalid) state_reg <= ST_READ;
                ST_READ: state_reg <= ST_WAIT;
                ST_WAIT: state_reg <= ST_DECIDE;
                ST_DECIDE: begin
                    sel_reg <= blmt_pkg::DIV_ENERGY;
                    if (sts.action == blmt_pkg::ACT_TRAIN || !sts.addr_ok || sts.cnt_zero
                        || sts.action == blmt_pkg::ACT_UNUSED)
                        state_reg <= ST_LOAD;
                    else state_reg <= ST_DIV;
                end
                ST_DIV: state_reg <= ST_DIVW;
                ST_DIVW: if (sts.div_done) begin
                    if (sel_reg == blmt_pkg::DIV_AZIMUTH) state_reg <= ST_LOAD;
                    else begin
                        sel_reg <= sel_reg + 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_LOAD: if (out_free) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/blmt_checker.sv -----
// Port-level checker for the binned lookup mean table, bound to the top level.
module blmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[95:29] == '0) else $error("miss with means");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("two words taken");
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid) else $error("ready after reset");
endmodule

bind binned_lookup_mean_table_core blmt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
